// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the ADPCM decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Concurrent check on an explicit clock and active-low reset
`define ASSERT_CLK_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Concurrent check on the default clock and reset names
`define ASSERT_DEF(lbl, prop, msg) \
  `ASSERT_CLK_RST(lbl, clk_i, rst_ni, prop, msg)
`else
`define ASSERT_CLK_RST(lbl, clk, rstn, prop, msg)
`define ASSERT_DEF(lbl, prop, msg)
`endif
`endif

// ===== hdl/imadec_pkg.sv =====
// Package with widths, register indexes and ADPCM tables of the decoder.
package imadec_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned IndexW  = 7;
  localparam int unsigned StepW   = 15;
  localparam int unsigned CodeW   = 4;
  localparam int unsigned CfgAddrW = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [IndexW-1:0] MaxIndex = 7'd88;

  // Register indexes of the configuration port
  localparam logic [CfgAddrW-1:0] RegStartPredictor = 1'b0;
  localparam logic [CfgAddrW-1:0] RegStartIndex     = 1'b1;

  // Step size for a step index in 0..88
  function automatic logic [StepW-1:0] step_size(input logic [IndexW-1:0] idx);
    logic [StepW-1:0] s;
    case (idx)
      7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
      7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
      7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
      7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
      7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
      7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
      7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
      7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
      7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
      7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
      7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
      7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
      7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
      7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
      7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
      7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
      7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
      7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
      7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
      7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
      7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
      7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
      7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
      7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
      7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
      7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
      7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
      7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
      7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
      7'd87: s = 15'd29794; 7'd88: s = 15'd32767;
      default: s = 15'd32767;
    endcase
    return s;
  endfunction

  // Signed index move for the code magnitude (bits 2:0)
  function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
    logic signed [4:0] a;
    case (mag)
      3'd4:    a = 5'sd2;
      3'd5:    a = 5'sd4;
      3'd6:    a = 5'sd6;
      3'd7:    a = 5'sd8;
      default: a = -5'sd1;
    endcase
    return a;
  endfunction

endpackage

// ===== hdl/imadec_nibble.sv =====
// Combinational decode of one 4-bit ADPCM code against predictor and step index.
module imadec_nibble (
  input  logic [imadec_pkg::CodeW-1:0]  code_i,
  input  logic [imadec_pkg::SampleW-1:0] pred_i,
  input  logic [imadec_pkg::IndexW-1:0] index_i,
  output logic [imadec_pkg::SampleW-1:0] pred_o,
  output logic [imadec_pkg::IndexW-1:0] index_o
);

  logic [imadec_pkg::StepW-1:0] step;
  logic [imadec_pkg::SampleW-1:0] diff;
  logic signed [imadec_pkg::SampleW+1:0] sum;
  logic signed [4:0] adj;
  logic signed [imadec_pkg::IndexW:0] idx_sum;

  // Difference magnitude: step/8 plus the selected fractions
  always_comb begin
    step = imadec_pkg::step_size(index_i);
    diff = {4'd0, step[imadec_pkg::StepW-1:3]};
    if (code_i[2]) diff = diff + {1'b0, step};
    if (code_i[1]) diff = diff + {2'd0, step[imadec_pkg::StepW-1:1]};
    if (code_i[0]) diff = diff + {3'd0, step[imadec_pkg::StepW-1:2]};
  end

  // Predictor update with signed 16-bit saturation
  always_comb begin
    if (code_i[3]) begin
      sum = {{2{pred_i[imadec_pkg::SampleW-1]}}, pred_i} - $signed({2'b00, diff});
    end else begin
      sum = {{2{pred_i[imadec_pkg::SampleW-1]}}, pred_i} + $signed({2'b00, diff});
    end
    if (sum > 18'sd32767) begin
      pred_o = 16'h7fff;
    end else if (sum < -18'sd32768) begin
      pred_o = 16'h8000;
    end else begin
      pred_o = sum[imadec_pkg::SampleW-1:0];
    end
  end

  // Step index move, clamped to 0..88
  always_comb begin
    adj     = imadec_pkg::index_adjust(code_i[2:0]);
    idx_sum = $signed({1'b0, index_i})
            + $signed({{(imadec_pkg::IndexW-4){adj[4]}}, adj});
    if (idx_sum < 0) begin
      index_o = '0;
    end else if (idx_sum > $signed({1'b0, imadec_pkg::MaxIndex})) begin
      index_o = imadec_pkg::MaxIndex;
    end else begin
      index_o = idx_sum[imadec_pkg::IndexW-1:0];
    end
  end

endmodule

// ===== hdl/ima_adpcm_decoder.sv =====
// Top level of the IMA ADPCM decoder: item register, nibble decode, result register.
//
//  channel   dir  tdata                tuser                    tlast
//  s_axis    in   [7:0] code_byte      [0] emit_both [1] restart  -
//  m_axis    out  [15:0] sample        -                        last
//  cfg       in   cfg_addr_i 0 start_predictor, 1 start_index; data cfg_wdata_i
//
// One nibble is decoded per cycle unless the result register stalls: a byte
// with both nibbles gives its high nibble, then its low nibble, a single-nibble
// byte only its high nibble; the decoder state loop (predictor, step index) sets
// this rate. Each result passes the item register, then the result register.
// Reset clears the state, the configuration registers and all valid flags.
// A stalled result register holds decoding; a new item is taken in the cycle
// the last nibble of the held item moves to the result register.
`include "assert_macros.svh"

module ima_adpcm_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [imadec_pkg::CfgAddrW-1:0]     cfg_addr_i,
  input  logic [imadec_pkg::CfgDataW-1:0]     cfg_wdata_i,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] code_byte
  input  logic [1:0]  s_axis_tuser,   // [0] emit_both, [1] restart
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] sample
  output logic        m_axis_tlast
);

  logic [imadec_pkg::SampleW-1:0] start_pred_q;
  logic [imadec_pkg::IndexW-1:0]  start_idx_q;

  logic [imadec_pkg::SampleW-1:0] pred_q;
  logic [imadec_pkg::IndexW-1:0]  idx_q;

  logic       stage_valid_q, stage_valid_d;
  logic       phase_q, phase_d;
  logic [7:0] code_q;
  logic       both_q;
  logic       restart_q;

  logic                           out_valid_q;
  logic [imadec_pkg::SampleW-1:0] out_sample_q;
  logic                           out_last_q;

  logic                           out_free, advance, last_nib, in_take;
  logic [imadec_pkg::CodeW-1:0]   nib;
  logic [imadec_pkg::SampleW-1:0] pred_in, pred_new;
  logic [imadec_pkg::IndexW-1:0]  idx_in, idx_new;

  // Configuration registers; the start index is stored as written and limited to 88 where it is used
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_pred_q <= '0;
      start_idx_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        imadec_pkg::RegStartPredictor: start_pred_q <= cfg_wdata_i;
        imadec_pkg::RegStartIndex:     start_idx_q  <= cfg_wdata_i[imadec_pkg::IndexW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake and sequencing
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = stage_valid_q && out_free;
  assign last_nib      = phase_q || !both_q;
  assign s_axis_tready = !stage_valid_q || (out_free && last_nib);
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    stage_valid_d = stage_valid_q;
    phase_d       = phase_q;
    if (in_take) begin
      stage_valid_d = 1'b1;
      phase_d       = 1'b0;
    end else if (advance && last_nib) begin
      stage_valid_d = 1'b0;
    end else if (advance) begin
      phase_d = 1'b1;
    end
  end

  // Decode input: restart loads the start values before the high nibble
  always_comb begin
    nib = phase_q ? code_q[3:0] : code_q[7:4];
    if (restart_q && !phase_q) begin
      pred_in = start_pred_q;
      idx_in  = (start_idx_q > imadec_pkg::MaxIndex) ? imadec_pkg::MaxIndex : start_idx_q;
    end else begin
      pred_in = pred_q;
      idx_in  = idx_q;
    end
  end

  imadec_nibble u_nibble (
    .code_i  (nib),
    .pred_i  (pred_in),
    .index_i (idx_in),
    .pred_o  (pred_new),
    .index_o (idx_new)
  );

  // Item register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      phase_q       <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
      phase_q       <= phase_d;
    end
  end

  // Item register payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      code_q    <= s_axis_tdata;
      both_q    <= s_axis_tuser[0];
      restart_q <= s_axis_tuser[1];
    end
  end

  // Decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pred_q <= '0;
      idx_q  <= '0;
    end else if (advance) begin
      pred_q <= pred_new;
      idx_q  <= idx_new;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_sample_q <= pred_new;
      out_last_q   <= last_nib;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_sample_q;
  assign m_axis_tlast  = out_last_q;

  // Checks
  `ASSERT_DEF(a_idx_range, idx_q <= imadec_pkg::MaxIndex, "step index above 88")
  `ASSERT_DEF(a_pair_blocks_input, (stage_valid_q && !phase_q && both_q) |-> !s_axis_tready, "input taken before second nibble")
  `ASSERT_DEF(a_first_has_second, (out_valid_q && !out_last_q) |-> (stage_valid_q && phase_q), "first nibble shown without second pending")
  `ASSERT_DEF(a_state_moves_with_result, (!advance) |=> ($stable(pred_q) && $stable(idx_q)), "state changed without a decode")

endmodule
